// ===== rtl/vpd_pkg.sv =====
// Shared types, codes and constants of the varint packet deframer.
package vpd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int CFG_WIDTH           = 24;
   localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 24'd2097151;

   localparam logic [6:0] VAL_MASK   = 7'h7F;
   localparam int         CONT_BIT   = 7;
   localparam logic [2:0] MAX_VARINT = 3'd5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_AW = 3;
   localparam logic CSR_MAX_LEN_IDX = 1'b0;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] CAUSE_NONE      = 2'd0;
   localparam logic [1:0] CAUSE_LEN_LONG  = 2'd1;
   localparam logic [1:0] CAUSE_LEN_RANGE = 2'd2;
   localparam logic [1:0] CAUSE_ID_BAD    = 2'd3;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_ID,
      PH_PAYLOAD,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] packet_id;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_cause;
   } result_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== rtl/vpd_front.sv =====
// Front end: accepts stream bytes, decodes the varints and classifies each beat.
module vpd_front #(
   parameter int LENGTH_BITS = vpd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [7:0]                      in_byte,
   output logic                            in_ready,
   input  logic [vpd_pkg::CFG_WIDTH-1:0]   max_len,
   input  vpd_pkg::queue_status_type       q_status,
   output logic                            push,
   output vpd_pkg::result_type             push_data
);
   import vpd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [31:0]            acc_ff, acc_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [31:0]            id_ff, id_in;

   logic [5:0]             shamt;
   logic [31:0]            acc_abs;
   logic [2:0]             cnt_inc;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                   accept;
   logic                   len_bad;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   // Seven value bits per byte; bits shifted past bit 31 fall away.
   assign shamt   = {cnt_ff, 3'b000} - {3'b000, cnt_ff};
   assign acc_abs = acc_ff | (32'(in_byte & {1'b0, VAL_MASK}) << shamt);
   assign cnt_inc = cnt_ff + 3'd1;
   assign rem_dec = rem_ff - LENGTH_BITS'(1);

   assign len_bad = (acc_abs == 32'd0) || acc_abs[31]
                    || (acc_abs > {{(32-CFG_WIDTH){1'b0}}, max_len})
                    || ((acc_abs >> LENGTH_BITS) != 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         id_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         id_ff    <= id_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      id_in     = id_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         case (phase_ff)
            PH_LEN: begin
               if (in_byte[CONT_BIT]) begin
                  if (cnt_inc >= MAX_VARINT) begin
                     phase_in              = PH_ERROR;
                     acc_in                = '0;
                     cnt_in                = '0;
                     rem_in                = '0;
                     push                  = 1'b1;
                     push_data.kind        = KIND_ERROR;
                     push_data.error_cause = CAUSE_LEN_LONG;
                  end else begin
                     acc_in = acc_abs;
                     cnt_in = cnt_inc;
                  end
               end else if (len_bad) begin
                  phase_in              = PH_ERROR;
                  acc_in                = '0;
                  cnt_in                = '0;
                  rem_in                = '0;
                  push                  = 1'b1;
                  push_data.kind        = KIND_ERROR;
                  push_data.error_cause = CAUSE_LEN_RANGE;
               end else begin
                  rem_in   = acc_abs[LENGTH_BITS-1:0];
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               rem_in = rem_dec;
               if (in_byte[CONT_BIT]) begin
                  if (cnt_inc >= MAX_VARINT || rem_dec == '0) begin
                     phase_in              = PH_ERROR;
                     acc_in                = '0;
                     cnt_in                = '0;
                     rem_in                = '0;
                     push                  = 1'b1;
                     push_data.kind        = KIND_ERROR;
                     push_data.error_cause = CAUSE_ID_BAD;
                  end else begin
                     acc_in = acc_abs;
                     cnt_in = cnt_inc;
                  end
               end else begin
                  id_in               = acc_abs;
                  acc_in              = '0;
                  cnt_in              = '0;
                  phase_in            = (rem_dec == '0) ? PH_LEN : PH_PAYLOAD;
                  push                = 1'b1;
                  push_data.kind      = KIND_HEADER;
                  push_data.packet_id = acc_abs;
                  push_data.last      = (rem_dec == '0);
               end
            end
            PH_PAYLOAD: begin
               rem_in                 = rem_dec;
               phase_in               = (rem_dec == '0) ? PH_LEN : PH_PAYLOAD;
               push                   = 1'b1;
               push_data.kind         = KIND_PAYLOAD;
               push_data.packet_id    = id_ff;
               push_data.payload_byte = in_byte;
               push_data.last         = (rem_dec == '0);
            end
            default: begin
               // After a framing error every beat is swallowed until reset.
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

endmodule

// ===== rtl/vpd_queue.sv =====
// Short result queue that decouples the decoder from the output stage.
module vpd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vpd_pkg::result_type        push_data,
   input  logic                       pop,
   output vpd_pkg::result_type        head,
   output vpd_pkg::queue_status_type  status
);
   import vpd_pkg::*;

   result_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/vpd_back.sv =====
// Back end: output register that drains the queue onto the result channel.
module vpd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vpd_pkg::queue_status_type  q_status,
   input  vpd_pkg::result_type        head,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output vpd_pkg::result_type        out_data
);
   import vpd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register refills in the same cycle that its beat is taken.
   assign pop       = !q_status.empty && (!valid_ff || out_ready);
   assign valid_in  = pop || (valid_ff && !out_ready);
   assign data_in   = pop ? head : data_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/varint_packet_deframer_top.sv =====
// A byte that yields a result goes through the result queue and then the output register to rsp_.
// Throughput: one byte per cycle; the decoder stalls only when the 4-entry result queue
// is full, and the output register refills in the cycle its beat is taken.
// Reset: synchronous, active high; decoder returns to awaiting a length, queue and output
// empty, the length limit back to 2097151. A framing error stays in force until reset.
// Top level of the varint packet deframer.
module varint_packet_deframer_top #(
   parameter int LENGTH_BITS = vpd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_stream_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_kind,
   output logic signed [31:0]           rsp_packet_id,
   output logic [7:0]                   rsp_payload_byte,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_error_cause,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vpd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import vpd_pkg::*;

   logic [CFG_WIDTH-1:0] max_len_ff, max_len_in;
   logic                 csr_write;
   logic                 csr_hit;

   logic                 push;
   logic                 pop;
   result_type           push_data;
   result_type           head;
   result_type           out_data;
   queue_status_type     q_status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1] == CSR_MAX_LEN_IDX);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign max_len_in = (csr_write && csr_hit) ? csr_pwdata[CFG_WIDTH-1:0] : max_len_ff;
   assign csr_prdata = csr_hit ? {{(32-CFG_WIDTH){1'b0}}, max_len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   vpd_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_byte   (req_stream_byte),
      .in_ready  (req_ready),
      .max_len   (max_len_ff),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   vpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   vpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_packet_id    = out_data.packet_id;
   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_last         = out_data.last;
   assign rsp_error_cause  = out_data.error_cause;

endmodule

// ===== rtl/vpd_checker.sv =====
// Port-level checks on the deframer's result channel, bound to the top level.
module vpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_kind,
   input logic signed [31:0] rsp_packet_id,
   input logic [7:0]         rsp_payload_byte,
   input logic               rsp_last,
   input logic [1:0]         rsp_error_cause
);
   import vpd_pkg::*;

   // Once the error beat has gone out, the block falls silent.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_ERROR |=> !rsp_valid)
      else $error("result after framing error");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |->
         rsp_packet_id == 32'sd0 && rsp_payload_byte == 8'd0 && !rsp_last)
      else $error("error beat carries packet fields");

   a_cause_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_cause != CAUSE_NONE)))
      else $error("error cause does not match kind");

   a_header_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER |-> rsp_payload_byte == 8'd0)
      else $error("header beat carries a payload byte");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_packet_id) && $stable(rsp_payload_byte))
      else $error("stalled result changed");

endmodule

bind varint_packet_deframer_top vpd_checker u_vpd_checker (.*);
